// File: hdl/priority_wait_queue_macros.svh
// ----------------------------------------------------------------------------
// priority_wait_queue assertion macros
// Shorthand for the clocked, reset-qualified properties of the wait queue.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_WAIT_QUEUE_MACROS_SVH
`define PRIORITY_WAIT_QUEUE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pwq_pkg.sv
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared widths, operation codes and the result record of the wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pwq_pkg;

    // Default sizes of the queue storage.
    localparam int DEF_QUEUE_DEPTH    = 32;
    localparam int DEF_ID_WIDTH       = 8;
    localparam int DEF_PRIORITY_WIDTH = 8;

    // Widths of the transaction fields on the ports.
    localparam int OP_W         = 3;
    localparam int ID_FIELD_W   = 8;
    localparam int PRIO_FIELD_W = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ARM      = 3'd0;
    localparam logic [OP_W-1:0] OP_DISARM   = 3'd1;
    localparam logic [OP_W-1:0] OP_RESLOT   = 3'd2;
    localparam logic [OP_W-1:0] OP_WAKE_ONE = 3'd3;
    localparam logic [OP_W-1:0] OP_WAKE_ALL = 3'd4;

    // One result transaction.
    typedef struct packed {
        logic                    woken_valid;
        logic [ID_FIELD_W-1:0]   woken_id;
        logic                    found;
        logic                    top_changed;
        logic [PRIO_FIELD_W-1:0] head_prio;
        logic                    error;
        logic                    last;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/priority_wait_queue.sv
// ----------------------------------------------------------------------------
// priority_wait_queue
// Waiters kept sorted by priority (lower first, arrival order among equals)
// in one entry memory that a small sequencer scans and shifts one slot at a
// time through its single read port and single write port.
// ----------------------------------------------------------------------------
// Refused or trivial commands answer without touching the memory; a missing id
// or a duplicate arm answers after a scan of the entries. Disarm and arm scan
// and then shift the entries behind the slot; reslot scans and shifts twice;
// wake one shifts every entry down. Wake all reads the head first and then
// gives one result per cycle. A new command is taken in the cycle of the last
// result. Synchronous reset empties the queue only.
`default_nettype none

module priority_wait_queue #(
    parameter int QUEUE_DEPTH    = pwq_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH       = pwq_pkg::DEF_ID_WIDTH,
    parameter int PRIORITY_WIDTH = pwq_pkg::DEF_PRIORITY_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [pwq_pkg::OP_W-1:0]          i_operation,
    input  wire logic [pwq_pkg::ID_FIELD_W-1:0]    i_thread_id,
    input  wire logic [pwq_pkg::PRIO_FIELD_W-1:0]  i_priority_req,
    output logic                                   o_strobe,
    output logic                                   o_woken_valid,
    output logic [pwq_pkg::ID_FIELD_W-1:0]         o_woken_id,
    output logic                                   o_found,
    output logic                                   o_top_changed,
    output logic [pwq_pkg::PRIO_FIELD_W-1:0]       o_head_prio,
    output logic                                   o_error,
    output logic                                   o_last
);

    import pwq_pkg::*;

    // Derived sizes.
    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W   = (ID_WIDTH < ID_FIELD_W) ? ID_WIDTH : ID_FIELD_W;
    localparam logic [PRIORITY_WIDTH-1:0] EMPTY_PRIO = '1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_INS_RD  = 4'd2;
    localparam logic [3:0] S_INS_WR  = 4'd3;
    localparam logic [3:0] S_RM_RD   = 4'd4;
    localparam logic [3:0] S_RM_WR   = 4'd5;
    localparam logic [3:0] S_POP     = 4'd6;
    localparam logic [3:0] S_FIN_RD  = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;
    localparam logic [3:0] S_WA_HEAD = 4'd9;
    localparam logic [3:0] S_WA_EMIT = 4'd10;

    // Builds one result record.
    function automatic t_result f_result(
        input logic                      valid,
        input logic [ID_W-1:0]           id,
        input logic                      found,
        input logic                      changed,
        input logic [PRIORITY_WIDTH-1:0] top,
        input logic                      err,
        input logic                      fin
    );
        t_result res;
        res.woken_valid  = valid;
        res.woken_id     = ID_FIELD_W'(id);
        res.found        = found;
        res.top_changed  = changed;
        res.head_prio    = PRIO_FIELD_W'(top);
        res.error        = err;
        res.last         = fin;
        return res;
    endfunction

    // Entry memory and its registered read data.
    logic [ID_W-1:0]           r_mem_id   [QUEUE_DEPTH];
    logic [PRIORITY_WIDTH-1:0] r_mem_prio [QUEUE_DEPTH];
    logic [ID_W-1:0]           r_rd_id;
    logic [PRIORITY_WIDTH-1:0] r_rd_prio;

    // Control state.
    logic [3:0]                r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [PRIORITY_WIDTH-1:0] r_best, n_best;
    logic                      r_strobe, n_strobe;

    // Operation payload and work registers.
    logic [OP_W-1:0]           r_op, n_op;
    logic [ID_W-1:0]           r_id, n_id;
    logic [PRIORITY_WIDTH-1:0] r_prio, n_prio;
    logic [CNT_W-1:0]          r_idx, n_idx;
    logic [CNT_W-1:0]          r_pos, n_pos;
    logic                      r_pos_set, n_pos_set;
    logic                      r_ins, n_ins;
    logic [ID_W-1:0]           r_popped, n_popped;
    t_result                   r_res, n_res;

    // Memory port controls.
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ID_W-1:0]           wr_id;
    logic [PRIORITY_WIDTH-1:0] wr_prio;
    logic [ADDR_W-1:0]         rd_addr;

    // Helper values.
    logic [CNT_W-1:0]          idx_inc, idx_inc2, idx_dec;
    logic [PRIORITY_WIDTH-1:0] prio_in, prio_sat, new_best, wa_top;
    logic                      id_match, prio_gt, scan_end, wa_more;

    assign idx_inc  = r_idx + CNT_W'(1);
    assign idx_inc2 = r_idx + CNT_W'(2);
    assign idx_dec  = r_idx - CNT_W'(1);
    assign prio_in  = i_priority_req[PRIORITY_WIDTH-1:0];
    assign prio_sat = (prio_in == EMPTY_PRIO) ? (EMPTY_PRIO - PRIORITY_WIDTH'(1)) : prio_in;
    assign id_match = (r_rd_id == r_id);
    assign prio_gt  = (r_rd_prio > r_prio);
    assign scan_end = (idx_inc == r_count);
    assign new_best = (r_count != '0) ? r_rd_prio : EMPTY_PRIO;
    assign wa_more  = (idx_inc < r_count);
    assign wa_top   = wa_more ? r_rd_prio : EMPTY_PRIO;

    // Sequencer next-state and memory port logic.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_best    = r_best;
        n_strobe  = 1'b0;
        n_op      = r_op;
        n_id      = r_id;
        n_prio    = r_prio;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_pos_set = r_pos_set;
        n_ins     = r_ins;
        n_popped  = r_popped;
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_addr   = r_idx[ADDR_W-1:0];
        wr_id     = r_rd_id;
        wr_prio   = r_rd_prio;
        rd_addr   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op      = i_operation;
                    n_id      = i_thread_id[ID_W-1:0];
                    n_prio    = prio_sat;
                    n_idx     = '0;
                    n_pos     = '0;
                    n_pos_set = 1'b0;
                    unique case (i_operation) inside
                        OP_ARM: begin
                            n_ins = 1'b1;
                            if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                                // Full queue refuses the arm.
                                n_strobe = 1'b1;
                                n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b1, 1'b1);
                            end else if (r_count == '0) begin
                                n_state = S_INS_RD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_DISARM, OP_RESLOT: begin
                            n_ins = 1'b0;
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b0, 1'b1);
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_WAKE_ONE, OP_WAKE_ALL: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b0, 1'b1);
                            end else if (i_operation == OP_WAKE_ONE) begin
                                n_state = S_POP;
                            end else begin
                                n_state = S_WA_HEAD;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b0, 1'b1);
                        end
                    endcase
                end
            end

            // One entry per cycle; the next one is read while this one is checked.
            S_SCAN: begin
                rd_addr = idx_inc[ADDR_W-1:0];
                if (r_ins) begin
                    if (r_op == OP_ARM && id_match) begin
                        n_strobe = 1'b1;
                        n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b1, 1'b1);
                        n_state  = S_IDLE;
                    end else begin
                        if (prio_gt && !r_pos_set) begin
                            n_pos     = r_idx;
                            n_pos_set = 1'b1;
                        end
                        if (scan_end) begin
                            n_state = S_INS_RD;
                            n_idx   = r_count;
                            if (!r_pos_set && !prio_gt) begin
                                n_pos = r_count;
                            end
                        end else begin
                            n_idx = idx_inc;
                        end
                    end
                end else begin
                    if (id_match) begin
                        n_state = S_RM_RD;
                    end else if (scan_end) begin
                        n_strobe = 1'b1;
                        n_res    = f_result(1'b0, '0, 1'b0, 1'b0, r_best, 1'b0, 1'b1);
                        n_state  = S_IDLE;
                    end else begin
                        n_idx = idx_inc;
                    end
                end
            end

            // Open a hole at the insert position, moving entries up from the tail.
            S_INS_RD: begin
                if (r_idx == r_pos) begin
                    wr_en   = 1'b1;
                    wr_id   = r_id;
                    wr_prio = r_prio;
                    n_count = r_count + CNT_W'(1);
                    n_state = S_FIN_RD;
                end else begin
                    rd_addr = idx_dec[ADDR_W-1:0];
                    n_state = S_INS_WR;
                end
            end

            S_INS_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_dec;
                n_state = S_INS_RD;
            end

            // Close the gap at the removed slot, moving entries down.
            S_RM_RD: begin
                if (scan_end) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_op == OP_RESLOT) begin
                        n_ins     = 1'b1;
                        n_idx     = '0;
                        n_pos     = '0;
                        n_pos_set = 1'b0;
                        n_state   = (r_count == CNT_W'(1)) ? S_INS_RD : S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    rd_addr = idx_inc[ADDR_W-1:0];
                    n_state = S_RM_WR;
                end
            end

            S_RM_WR: begin
                wr_en   = 1'b1;
                n_idx   = idx_inc;
                n_state = S_RM_RD;
            end

            // Head entry is in the read register; keep its id and remove slot zero.
            S_POP: begin
                n_popped = r_rd_id;
                n_idx    = '0;
                n_state  = S_RM_RD;
            end

            // Head is read after the last write has landed.
            S_FIN_RD: begin
                n_state = S_FIN;
            end

            S_FIN: begin
                n_strobe = 1'b1;
                n_best   = new_best;
                n_res    = f_result(r_op == OP_WAKE_ONE,
                                    (r_op == OP_WAKE_ONE) ? r_popped : '0,
                                    r_op == OP_DISARM || r_op == OP_RESLOT,
                                    new_best != r_best, new_best, 1'b0, 1'b1);
                n_state  = S_IDLE;
            end

            // Wake all walks the entries in order without moving them.
            S_WA_HEAD: begin
                n_popped = r_rd_id;
                rd_addr  = idx_inc[ADDR_W-1:0];
                n_state  = S_WA_EMIT;
            end

            S_WA_EMIT: begin
                n_strobe = 1'b1;
                n_res    = f_result(1'b1, r_popped, 1'b0, wa_top != r_best, wa_top,
                                    1'b0, !wa_more);
                n_best   = wa_top;
                n_popped = r_rd_id;
                if (wa_more) begin
                    n_idx   = idx_inc;
                    rd_addr = idx_inc2[ADDR_W-1:0];
                end else begin
                    n_count = '0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_id[wr_addr]   <= wr_id;
            r_mem_prio[wr_addr] <= wr_prio;
        end
        r_rd_id   <= r_mem_id[rd_addr];
        r_rd_prio <= r_mem_prio[rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_best   <= EMPTY_PRIO;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_best   <= n_best;
            r_strobe <= n_strobe;
        end
    end

    // Payload and work registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_id      <= n_id;
        r_prio    <= n_prio;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_pos_set <= n_pos_set;
        r_ins     <= n_ins;
        r_popped  <= n_popped;
        r_res     <= n_res;
    end

    // Outputs.
    assign busy           = (r_state != S_IDLE);
    assign o_strobe       = r_strobe;
    assign o_woken_valid  = r_res.woken_valid;
    assign o_woken_id     = r_res.woken_id;
    assign o_found        = r_res.found;
    assign o_top_changed  = r_res.top_changed;
    assign o_head_prio    = r_res.head_prio;
    assign o_error        = r_res.error;
    assign o_last         = r_res.last;

    // Checks on the sequencer.
`include "priority_wait_queue_macros.svh"

    `PWQ_ASSERT_NEXT(a_start_answered, start && !busy, o_strobe || busy, "command dropped")
    `PWQ_ASSERT_SAME(a_error_keeps_count, o_strobe && o_error, $stable(r_count), "refused arm moved count")
    `PWQ_ASSERT_SAME(a_run_continues, o_strobe && !o_last, busy, "wake-all run cut short")
    `PWQ_ASSERT_SAME(a_empty_prio, !busy && r_count == '0, r_best == EMPTY_PRIO, "empty queue has a head")

endmodule

`default_nettype wire
